[sv/pkot_pkg.sv]
// Shared types and codes for the pair key occurrence table.
// Used by pkot_cell and pair_key_occurrence_table; depends on nothing.
package pkot_pkg;

  localparam int ADDR_W = 48;
  localparam int KEY_W  = 2 * ADDR_W;
  localparam int CNT_W  = 8;
  localparam int ID_W   = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;
  localparam logic [CNT_W-1:0] THRESH_RESET = 8'd4;

  // Result status codes.
  localparam logic [1:0] ST_NEW     = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  // Operation codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD = 1'b0;

  // Lookup word that marches down the row of cells.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic             found;
    logic             added;
    logic             done;
    logic [CNT_W-1:0] count;
  } query_t;

endpackage

[sv/pair_key_occurrence_table.sv]
// Top level of the pair key occurrence table: command port, register port,
// fill level and the row of pkot_cell entries. Depends on pkot_pkg.
//
// An add command passes from the edge that accepts it through the launch
// register, then each of the TABLE_DEPTH cells in turn, and then the result
// register after the last cell. busy is high from the accepting edge and
// drops as the result appears, so the next command can be accepted at the
// edge that ends the result cycle.
// A clear command gives its result in the next cycle and leaves busy low.
// Each result shows on the result ports for one cycle with result_valid high
// and must be taken then, since the receiver cannot stall the block.
module pair_key_occurrence_table
  import pkot_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  // Command channel.
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [ADDR_W-1:0] first_address,
  input  logic [ADDR_W-1:0] second_address,
  // Result channel.
  output logic              result_valid,
  output logic [1:0]        status,
  output logic [ID_W-1:0]   entry_id,
  output logic [CNT_W-1:0]  hit_count,
  output logic              just_completed,
  output logic [ID_W-1:0]   filled_entries,
  // Register port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0] threshold;
  logic [UW-1:0]    used;
  logic             accept;
  query_t           q_launch;
  query_t           q    [0:TABLE_DEPTH];
  logic [UW-1:0]    id   [0:TABLE_DEPTH];
  query_t           q_last;
  logic [UW-1:0]    id_last;

  assign accept = start && !busy;
  assign pready = 1'b1;

  // Register reads and writes.
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {24'd0, threshold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
      threshold <= pwdata[CNT_W-1:0];
    end
  end

  // Launch register feeding the first cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_launch.valid <= 1'b0;
    end else begin
      q_launch.valid <= accept && (func == FUNC_ADD);
    end
    if (accept) begin
      q_launch.key <= {first_address, second_address};
    end
    q_launch.found <= 1'b0;
    q_launch.added <= 1'b0;
    q_launch.done  <= 1'b0;
    q_launch.count <= '0;
  end

  assign q[0]  = q_launch;
  assign id[0] = '0;

  // Row of entries; the lookup word moves one cell per clock.
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    pkot_cell #(
      .IDX (k),
      .UW  (UW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .q_in      (q[k]),
      .id_in     (id[k]),
      .used      (used),
      .threshold (threshold),
      .q_out     (q[k+1]),
      .id_out    (id[k+1])
    );
  end

  assign q_last  = q[TABLE_DEPTH];
  assign id_last = id[TABLE_DEPTH];

  // Fill level, busy flag and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      used         <= '0;
      busy         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (accept && func == FUNC_CLEAR) begin
        used           <= '0;
        result_valid   <= 1'b1;
        status         <= ST_CLEARED;
        entry_id       <= '0;
        hit_count      <= '0;
        just_completed <= 1'b0;
        filled_entries <= '0;
      end else if (accept) begin
        busy <= 1'b1;
      end else if (q_last.valid) begin
        busy           <= 1'b0;
        result_valid   <= 1'b1;
        just_completed <= q_last.done && q_last.found;
        priority if (q_last.found) begin
          status         <= ST_UPDATED;
          entry_id       <= ID_W'(id_last);
          hit_count      <= q_last.count;
          filled_entries <= ID_W'(used);
        end else if (q_last.added) begin
          used           <= used + 1'b1;
          status         <= ST_NEW;
          entry_id       <= ID_W'(id_last);
          hit_count      <= q_last.count;
          filled_entries <= ID_W'(used + 1'b1);
        end else begin
          status         <= ST_FULL;
          entry_id       <= '0;
          hit_count      <= '0;
          filled_entries <= ID_W'(used);
        end
      end
    end
  end

endmodule

[sv/pkot_cell.sv]
// One table entry of the pair key occurrence table: key, count and a stage
// register for the lookup word passing through. Depends on pkot_pkg.
module pkot_cell
  import pkot_pkg::*;
#(
  parameter int IDX = 0,
  parameter int UW  = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  query_t               q_in,
  input  logic [UW-1:0]        id_in,
  input  logic [UW-1:0]        used,
  input  logic [CNT_W-1:0]     threshold,
  output query_t               q_out,
  output logic [UW-1:0]        id_out
);

  localparam logic [UW-1:0] MY_IDX = UW'(IDX);
  localparam logic [UW-1:0] MY_ID  = UW'(IDX + 1);

  logic [KEY_W-1:0] key;
  logic [CNT_W-1:0] count;
  logic             filled;
  logic             match;
  logic             slot;
  logic [CNT_W-1:0] count_inc;
  query_t           q_next;
  logic [UW-1:0]    id_next;

  // Compare against this entry only while it is filled; the first free
  // entry takes the key if nothing ahead matched.
  always_comb begin
    filled    = MY_IDX < used;
    match     = q_in.valid && !q_in.found && filled && (key == q_in.key);
    slot      = q_in.valid && !q_in.found && (MY_IDX == used);
    count_inc = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;
    q_next    = q_in;
    id_next   = id_in;
    if (match) begin
      q_next.found = 1'b1;
      q_next.count = count_inc;
      q_next.done  = (count != COUNT_MAX) && (count_inc == threshold);
      id_next      = MY_ID;
    end else if (slot) begin
      q_next.added = 1'b1;
      q_next.count = CNT_W'(1);
      q_next.done  = 1'b0;
      id_next      = MY_ID;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (match) begin
      count <= count_inc;
    end else if (slot) begin
      key   <= q_in.key;
      count <= CNT_W'(1);
    end
  end

  // Stage register toward the next cell; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_next.valid;
    end
    q_out.key   <= q_next.key;
    q_out.found <= q_next.found;
    q_out.added <= q_next.added;
    q_out.done  <= q_next.done;
    q_out.count <= q_next.count;
    id_out      <= id_next;
  end

endmodule

[sv/pkot_checker.sv]
// Port-level checks for pair_key_occurrence_table, attached by bind.
// Depends on pkot_pkg.
module pkot_checker
  import pkot_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              func,
  input logic              result_valid,
  input logic [1:0]        status,
  input logic [ID_W-1:0]   entry_id,
  input logic [CNT_W-1:0]  hit_count,
  input logic              just_completed,
  input logic [ID_W-1:0]   filled_entries
);

  // A clear command answers in the next cycle with status ST_CLEARED and zero entry_id, hit_count and filled_entries.
  a_clear_answer: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FUNC_CLEAR |=> result_valid && status == ST_CLEARED
      && entry_id == '0 && hit_count == '0 && filled_entries == '0)
    else $error("clear command did not give a cleared word");

  // An add command occupies the block.
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == FUNC_ADD |=> busy)
    else $error("add command did not raise busy");

  // A new entry starts at one and never reports completion.
  a_new_entry: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_NEW |-> hit_count == CNT_W'(1) && !just_completed
      && entry_id == filled_entries)
    else $error("new entry word is inconsistent");

  // A dropped item touches no entry.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |-> entry_id == '0 && hit_count == '0
      && !just_completed)
    else $error("dropped item reported an entry");

  // An add result ends the busy period.
  a_add_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_CLEARED |-> !busy)
    else $error("add result while still busy");

endmodule

bind pair_key_occurrence_table pkot_checker u_pkot_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .func           (func),
  .result_valid   (result_valid),
  .status         (status),
  .entry_id       (entry_id),
  .hit_count      (hit_count),
  .just_completed (just_completed),
  .filled_entries (filled_entries)
);

[sim/pair_key_occurrence_table_tb.sv]
// Self-checking testbench for pair_key_occurrence_table. Directed and random
// command words are checked against a behavioral copy of the occurrence table.
// Depends on pkot_pkg and the pair_key_occurrence_table RTL.
module pair_key_occurrence_table_tb;
  import pkot_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int ADD_LATENCY = TABLE_DEPTH + 2;
  localparam logic [2:0] THRESHOLD_ADDR = 3'(4 * REG_THRESHOLD);
  // Byte address of the first unmapped register slot.
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_WORDS = 160;
  localparam int POOL_SIZE = 96;

  // One result word as the table reports it.
  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  entry_id;
    logic [CNT_W-1:0] hit_count;
    logic             just_completed;
    logic [ID_W-1:0]  filled_entries;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              func;
  logic [ADDR_W-1:0] first_address;
  logic [ADDR_W-1:0] second_address;
  logic              result_valid;
  logic [1:0]        status;
  logic [ID_W-1:0]   entry_id;
  logic [CNT_W-1:0]  hit_count;
  logic              just_completed;
  logic [ID_W-1:0]   filled_entries;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // Behavioral copy of the table and its threshold register.
  logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [CNT_W-1:0] table_counts [TABLE_DEPTH];
  int               table_fill;
  logic [CNT_W-1:0] table_threshold;

  table_result_t expected_results [$];

  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int completions_seen = 0;
  int drops_seen = 0;
  int sender_idle_pct = 0;

  pair_key_occurrence_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .first_address (first_address),
    .second_address(second_address),
    .result_valid  (result_valid),
    .status        (status),
    .entry_id      (entry_id),
    .hit_count     (hit_count),
    .just_completed(just_completed),
    .filled_entries(filled_entries),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Free-running clock with a period of 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] random_address();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Applies one command word to the table copy and returns its result word.
  function automatic table_result_t predict_table_update(input logic op,
                                                         input logic [ADDR_W-1:0] a,
                                                         input logic [ADDR_W-1:0] b);
    table_result_t res;
    int hit_index;
    logic [CNT_W-1:0] cnt;
    res = '0;
    hit_index = -1;
    if (op == FUNC_CLEAR) begin
      table_fill = 0;
      res.status = ST_CLEARED;
    end else begin
      for (int i = 0; i < table_fill; i++)
        if (hit_index < 0 && table_keys[i] == {a, b}) hit_index = i;
      if (hit_index >= 0) begin
        // A saturated count stays put and can never complete again.
        cnt = table_counts[hit_index];
        if (cnt != COUNT_MAX) begin
          cnt = cnt + 1'b1;
          table_counts[hit_index] = cnt;
          res.just_completed = (cnt == table_threshold);
        end
        res.status = ST_UPDATED;
        res.entry_id = ID_W'(hit_index + 1);
        res.hit_count = cnt;
        res.filled_entries = ID_W'(table_fill);
      end else if (table_fill >= TABLE_DEPTH) begin
        res.status = ST_FULL;
        res.filled_entries = ID_W'(table_fill);
      end else begin
        table_keys[table_fill] = {a, b};
        table_counts[table_fill] = 8'd1;
        table_fill++;
        res.status = ST_NEW;
        res.entry_id = ID_W'(table_fill);
        res.hit_count = 8'd1;
        res.filled_entries = ID_W'(table_fill);
      end
    end
    return res;
  endfunction

  // Sends one command word, with an optional idle gap in front of it.
  task automatic send_word(input logic op, input logic [ADDR_W-1:0] a,
                           input logic [ADDR_W-1:0] b);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    start <= 1'b1;
    func <= op;
    first_address <= a;
    second_address <= b;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_table_update(op, a, b));
    words_sent++;
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_threshold_readback();
    logic [31:0] read_word;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= THRESHOLD_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    read_word = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (read_word[CNT_W-1:0] !== table_threshold) begin
      $error("completion_threshold readback mismatch: expected %0d, actual %0d",
             table_threshold, read_word[CNT_W-1:0]);
      error_count++;
    end
  endtask

  // Drains the block, then writes the threshold with junk in the upper bits.
  task automatic set_threshold(input logic [CNT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_write(THRESHOLD_ADDR, {24'($urandom), value});
    table_threshold = value;
    check_threshold_readback();
  endtask

  // Reset value, a normal write, and a write to an unmapped slot.
  task automatic test_register_port();
    check_threshold_readback();
    set_threshold(8'd9);
    apb_write(SPARE_ADDR, $urandom);
    check_threshold_readback();
  endtask

  // Address extremes, half-matching keys, completion and clear handling.
  task automatic test_directed_extremes();
    logic [ADDR_W-1:0] ones;
    ones = '1;
    set_threshold(8'd1);
    // A new entry never reports completion, even with a threshold of one.
    send_word(FUNC_ADD, '0, '0);
    send_word(FUNC_ADD, '0, '0);
    send_word(FUNC_ADD, ones, ones);
    send_word(FUNC_ADD, ones, '0);
    send_word(FUNC_ADD, '0, ones);
    send_word(FUNC_ADD, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_word(FUNC_ADD, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    set_threshold(8'd2);
    send_word(FUNC_ADD, ones, ones);
    send_word(FUNC_ADD, ones, ones);
    send_word(FUNC_ADD, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    // Clears ignore their addresses and may follow each other directly.
    send_word(FUNC_CLEAR, ones, ones);
    send_word(FUNC_CLEAR, '0, '0);
    send_word(FUNC_ADD, ones, ones);
    send_word(FUNC_CLEAR, random_address(), random_address());
    send_word(FUNC_ADD, '0, ones);
    send_word(FUNC_ADD, '0, ones);
  endtask

  // With a zero threshold no hit can ever complete.
  task automatic test_threshold_zero();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    a = random_address();
    b = random_address();
    set_threshold(8'd0);
    send_word(FUNC_CLEAR, a, b);
    repeat (5) send_word(FUNC_ADD, a, b);
    send_word(FUNC_ADD, b, a);
  endtask

  // Fill every entry, then show that new keys drop while hits still count.
  task automatic test_table_full();
    logic [ADDR_W-1:0] fill_first [TABLE_DEPTH + 3];
    logic [ADDR_W-1:0] fill_second [TABLE_DEPTH + 3];
    set_threshold(8'd3);
    send_word(FUNC_CLEAR, '0, '0);
    for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
      fill_first[i] = random_address();
      fill_second[i] = random_address();
      fill_second[i][7:0] = 8'(i);
      send_word(FUNC_ADD, fill_first[i], fill_second[i]);
    end
    send_word(FUNC_ADD, fill_first[TABLE_DEPTH - 1], fill_second[TABLE_DEPTH - 1]);
    send_word(FUNC_ADD, fill_first[0], fill_second[0]);
    send_word(FUNC_ADD, fill_first[5], fill_second[5]);
    send_word(FUNC_ADD, fill_first[5], fill_second[5]);
    send_word(FUNC_ADD, fill_first[TABLE_DEPTH], fill_second[TABLE_DEPTH]);
    send_word(FUNC_CLEAR, random_address(), random_address());
  endtask

  // Drive one count up to its ceiling and past it.
  task automatic test_count_saturation();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    a = random_address();
    b = random_address();
    set_threshold(COUNT_MAX);
    send_word(FUNC_CLEAR, '0, '0);
    repeat (int'(COUNT_MAX) + 3) send_word(FUNC_ADD, a, b);
  endtask

  // Mostly keys from a pool so counts climb, plus near misses, fresh keys
  // and occasional clears; each phase uses its own idle rate and threshold.
  task automatic test_random_traffic();
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int idle_by_phase [RANDOM_PHASES];
    logic [KEY_W-1:0] key;
    int pool_span;
    int clear_pct;
    int pick;
    int flip_bit;
    idle_by_phase = '{0, 56, 27, 0};
    foreach (key_pool[k]) key_pool[k] = {random_address(), random_address()};
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(3))
        0: set_threshold(8'd1);
        1: set_threshold(COUNT_MAX);
        2: set_threshold(CNT_W'($urandom_range(2, 8)));
        default: set_threshold(CNT_W'($urandom_range(1, 255)));
      endcase
      sender_idle_pct = idle_by_phase[phase];
      pool_span = $urandom_range(6, POOL_SIZE);
      clear_pct = $urandom_range(0, 3);
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(99);
        key = key_pool[$urandom_range(pool_span - 1)];
        if (pick < clear_pct) begin
          send_word(FUNC_CLEAR, random_address(), random_address());
        end else if (pick < 10) begin
          send_word(FUNC_ADD, random_address(), random_address());
        end else begin
          // A single flipped bit must not match the pool key.
          if (pick < 16) begin
            flip_bit = $urandom_range(KEY_W - 1);
            key[flip_bit] = ~key[flip_bit];
          end
          send_word(FUNC_ADD, key[KEY_W-1 -: ADDR_W], key[ADDR_W-1:0]);
        end
      end
    end
    sender_idle_pct = 0;
  endtask

  // Compare each result word with the oldest expected one.
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: status %0d, entry_id %0d", status, entry_id);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
        if (entry_id !== want.entry_id) begin
          $error("entry_id mismatch: expected %0d, actual %0d", want.entry_id, entry_id);
          error_count++;
        end
        if (hit_count !== want.hit_count) begin
          $error("hit_count mismatch: expected %0d, actual %0d", want.hit_count, hit_count);
          error_count++;
        end
        if (just_completed !== want.just_completed) begin
          $error("just_completed mismatch: expected %0d, actual %0d",
                 want.just_completed, just_completed);
          error_count++;
        end
        if (filled_entries !== want.filled_entries) begin
          $error("filled_entries mismatch: expected %0d, actual %0d",
                 want.filled_entries, filled_entries);
          error_count++;
        end
      end
      if (just_completed === 1'b1) completions_seen++;
      if (status === ST_FULL) drops_seen++;
    end
  end

  // Reset, run each test in turn, drain and report.
  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    func <= FUNC_ADD;
    first_address <= '0;
    second_address <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    table_fill = 0;
    table_threshold = THRESH_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_register_port();
    test_directed_extremes();
    test_threshold_zero();
    test_table_full();
    test_count_saturation();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (ADD_LATENCY + 4) @(posedge clk);
    $display("Checked %0d result words for %0d command words under several thresholds.",
             results_checked, words_sent);
    $display("Saw %0d completions and %0d full-table drops.", completions_seen, drops_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
